### sv/e2c_pkg.sv
// Shared types and constants for the equirectangular-to-cubemap mapper.
// Holds request/result payload structs, face codes and the sine table builder.
// No dependencies.
package e2c_pkg;

  localparam int NUM_CH     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  typedef struct packed {
    logic [13:0] src_col;
    logic [12:0] src_row;
    logic [31:0] chan_in_0;
    logic [31:0] chan_in_1;
    logic [31:0] chan_in_2;
    logic [31:0] chan_in_3;
  } in_req_t;

  typedef struct packed {
    logic        size_ok;
    logic [2:0]  face;
    logic [11:0] face_col;
    logic [11:0] face_row;
    logic [31:0] chan_out_0;
    logic [31:0] chan_out_1;
    logic [31:0] chan_out_2;
    logic [31:0] chan_out_3;
  } out_res_t;

  // odd Taylor terms of sin(pi/2 * t), Q30
  localparam logic [63:0] COEF1 = 64'd1686629713;
  localparam logic [63:0] COEF3 = 64'd693598668;
  localparam logic [63:0] COEF5 = 64'd85569306;
  localparam logic [63:0] COEF7 = 64'd5026995;
  localparam logic [63:0] COEF9 = 64'd172272;

  // t is the table position in Q30 (0..1.0); result is Q0.15, saturated
  function automatic logic [14:0] quarter_entry(input logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] acc;
    logic [63:0] r;
    t2  = (t * t) >> 30;
    acc = COEF9;
    acc = COEF7 - ((t2 * acc) >> 30);
    acc = COEF5 - ((t2 * acc) >> 30);
    acc = COEF3 - ((t2 * acc) >> 30);
    acc = COEF1 - ((t2 * acc) >> 30);
    r   = (t * acc) >> 30;
    r   = (r + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[14:0];
  endfunction

endpackage

### sv/equirect_to_cubemap_mapper_unit.sv
// Equirectangular-to-cubemap pixel mapper, top level.
// Depends on e2c_pkg and e2c_sin_rom.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+--------------------------------
//  request | start, busy, in_req                | taken when start && !busy
//  result  | out_strobe, out_res                | one cycle per strobe, no stall
//  config  | cfg_we, cfg_idx, cfg_wdata         | written when cfg_we is high
//
// One request per cycle; busy stays low. The pipeline is a 29-step angle
// divider (one quotient bit per stage), address/ROM/multiply/select stages,
// a 16-step minor/major divider, then offset, face-size multiply and the
// output register. Reset clears valid bits, sets width 2048 and height 1024.
module equirect_to_cubemap_mapper_unit #(
  parameter int CHANNELS          = 4,
  parameter int MAX_SOURCE_HEIGHT = 8192,
  parameter int SINE_TABLE_DEPTH  = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  e2c_pkg::in_req_t                  in_req,
  output logic                              out_strobe,
  output e2c_pkg::out_res_t                 out_res,
  input  logic                              cfg_we,
  input  logic [e2c_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [e2c_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import e2c_pkg::*;

  localparam int ANG_STEPS  = 29;
  localparam int QDIV_STEPS = 16;
  localparam int SIN_IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int META_LAT   = ANG_STEPS + 4 + QDIV_STEPS + 2;

  typedef struct packed {
    logic                       size_ok;
    logic [CHANNELS-1:0][31:0]  ch;
  } meta_t;

  typedef struct packed {
    logic [13:0] x;
    logic [12:0] y;
    logic [13:0] rl;
    logic [13:0] rt;
    logic [15:0] ql;
    logic [15:0] qt;
  } ang_t;

  typedef struct packed {
    logic [30:0] maj;
    logic [31:0] ru;
    logic [31:0] rv;
    logic [15:0] qu;
    logic [15:0] qv;
    logic        nu;
    logic        nv;
    logic        zmaj;
    face_t       face;
  } qd_t;

  logic [14:0]           src_w_r;
  logic [13:0]           src_h_r;
  logic                  size_ok;
  logic                  accept;
  logic [META_LAT-1:0]   vld_r;
  meta_t                 meta_in;
  meta_t                 meta_r [META_LAT];
  logic [NUM_CH-1:0][31:0] in_ch;
  logic [12:0]           fsize;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 15'd2048;
      src_h_r <= 14'd1024;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SOURCE_WIDTH:  src_w_r <= cfg_wdata;
        REG_SOURCE_HEIGHT: src_h_r <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign fsize   = src_h_r[13:1];
  assign size_ok = (src_h_r != 14'd0) && (src_h_r <= 14'(MAX_SOURCE_HEIGHT)) &&
                   (src_w_r == {src_h_r, 1'b0});

  assign in_ch[0] = in_req.chan_in_0;
  assign in_ch[1] = in_req.chan_in_1;
  assign in_ch[2] = in_req.chan_in_2;
  assign in_ch[3] = in_req.chan_in_3;

  assign meta_in.size_ok = size_ok;
  for (genvar c = 0; c < CHANNELS; c++) begin : g_min
    assign meta_in.ch[c] = in_ch[c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[META_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= meta_in;
    for (int i = 1; i < META_LAT; i++) begin
      meta_r[i] <= meta_r[i-1];
    end
  end

  // angle divider: floor({x,15'b0}/H) and floor({y,15'b0}/H), one bit per stage
  ang_t ang_r [ANG_STEPS];

  for (genvar k = 0; k < ANG_STEPS; k++) begin : g_ang
    ang_t        ang_src;
    ang_t        ang_nxt;
    logic [28:0] dl;
    logic [28:0] dt;
    logic [14:0] sl;
    logic [14:0] st;

    if (k == 0) begin : g_first
      assign ang_src = '{x: in_req.src_col, y: in_req.src_row,
                         rl: '0, rt: '0, ql: '0, qt: '0};
    end else begin : g_next
      assign ang_src = ang_r[k-1];
    end

    always_comb begin
      dl      = {ang_src.x, 15'b0};
      dt      = {1'b0, ang_src.y, 15'b0};
      sl      = {ang_src.rl, dl[28-k]};
      st      = {ang_src.rt, dt[28-k]};
      ang_nxt = ang_src;
      if (sl >= {1'b0, src_h_r}) begin
        ang_nxt.rl = 14'(sl - {1'b0, src_h_r});
        ang_nxt.ql = {ang_src.ql[14:0], 1'b1};
      end else begin
        ang_nxt.rl = sl[13:0];
        ang_nxt.ql = {ang_src.ql[14:0], 1'b0};
      end
      if (st >= {1'b0, src_h_r}) begin
        ang_nxt.rt = 14'(st - {1'b0, src_h_r});
        ang_nxt.qt = {ang_src.qt[14:0], 1'b1};
      end else begin
        ang_nxt.rt = st[13:0];
        ang_nxt.qt = {ang_src.qt[14:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      ang_r[k] <= ang_nxt;
    end
  end

  // {negate, table index} for a turn angle
  function automatic logic [SIN_IDX_W:0] sin_addr(input logic [15:0] a);
    logic [14:0] f;
    logic [27:0] p;
    f = a[14] ? 15'(15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
    p = 28'(f) * 28'(SINE_TABLE_DEPTH);
    return {a[15], p[14 +: SIN_IDX_W]};
  endfunction

  // order: 0 cos(lat), 1 sin(lat), 2 cos(lon), 3 sin(lon)
  logic [3:0][SIN_IDX_W-1:0] addr_a_r;
  logic [3:0]                neg_a_r;
  logic [3:0]                neg_b_r;
  logic [3:0][14:0]          rom_q;
  logic [15:0]               lat_turn;
  logic [15:0]               lon_turn;

  assign lon_turn = ang_r[ANG_STEPS-1].ql;
  assign lat_turn = ang_r[ANG_STEPS-1].qt;

  always_ff @(posedge clk) begin
    {neg_a_r[0], addr_a_r[0]} <= sin_addr(lat_turn);
    {neg_a_r[1], addr_a_r[1]} <= sin_addr(16'(lat_turn - 16'd16384));
    {neg_a_r[2], addr_a_r[2]} <= sin_addr(16'(lon_turn + 16'd16384));
    {neg_a_r[3], addr_a_r[3]} <= sin_addr(lon_turn);
    neg_b_r <= neg_a_r;
  end

  for (genvar r = 0; r < 4; r++) begin : g_rom
    e2c_sin_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom (
      .clk    (clk),
      .addr   (addr_a_r[r]),
      .data_r (rom_q[r])
    );
  end

  logic signed [15:0] trig [4];
  logic signed [31:0] vx_r;
  logic signed [31:0] vy_r;
  logic signed [31:0] vz_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      trig[i] = neg_b_r[i] ? -$signed({1'b0, rom_q[i]}) : $signed({1'b0, rom_q[i]});
    end
  end

  always_ff @(posedge clk) begin
    vx_r <= 32'(trig[0]) * 32'(trig[2]);
    vy_r <= 32'(trig[0]) * 32'(trig[3]);
    vz_r <= $signed({trig[1][15], trig[1], 15'b0});
  end

  function automatic logic [30:0] mag31(input logic signed [31:0] v);
    logic signed [31:0] n;
    n = -v;
    return v[31] ? n[30:0] : v[30:0];
  endfunction

  logic [30:0] ax;
  logic [30:0] ay;
  logic [30:0] az;
  logic        px;
  logic        py;
  logic        pz;
  qd_t         sel_nxt;
  qd_t         sel_r;

  always_comb begin
    ax = mag31(vx_r);
    ay = mag31(vy_r);
    az = mag31(vz_r);
    px = !vx_r[31] && (vx_r != 32'sd0);
    py = !vy_r[31] && (vy_r != 32'sd0);
    pz = !vz_r[31] && (vz_r != 32'sd0);
    sel_nxt    = '0;
    if (ax >= ay && ax >= az) begin
      sel_nxt.maj  = ax;
      sel_nxt.ru   = {1'b0, ay};
      sel_nxt.nu   = py;
      sel_nxt.rv   = {1'b0, az};
      sel_nxt.nv   = vz_r[31];
      sel_nxt.face = px ? FACE_POS_X : FACE_NEG_X;
    end else if (ay >= az) begin
      sel_nxt.maj  = ay;
      sel_nxt.ru   = {1'b0, ax};
      sel_nxt.nu   = vx_r[31];
      sel_nxt.rv   = {1'b0, az};
      sel_nxt.nv   = vz_r[31];
      sel_nxt.face = py ? FACE_POS_Y : FACE_NEG_Y;
    end else begin
      sel_nxt.maj  = az;
      sel_nxt.ru   = {1'b0, ax};
      sel_nxt.nu   = vx_r[31];
      sel_nxt.rv   = {1'b0, ay};
      sel_nxt.nv   = py;
      sel_nxt.face = pz ? FACE_POS_Z : FACE_NEG_Z;
    end
    sel_nxt.zmaj = (sel_nxt.maj == 31'd0);
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
  end

  // fractional divider: floor(|minor| * 2^15 / major), one bit per stage
  qd_t qd_r [QDIV_STEPS];

  for (genvar j = 0; j < QDIV_STEPS; j++) begin : g_qd
    qd_t         qd_src;
    qd_t         qd_nxt;
    logic [31:0] tu;
    logic [31:0] tv;
    logic        bu;
    logic        bv;

    if (j == 0) begin : g_first
      assign qd_src = sel_r;
      assign tu     = qd_src.ru;
      assign tv     = qd_src.rv;
    end else begin : g_next
      assign qd_src = qd_r[j-1];
      assign tu     = {qd_src.ru[30:0], 1'b0};
      assign tv     = {qd_src.rv[30:0], 1'b0};
    end

    always_comb begin
      bu        = tu >= {1'b0, qd_src.maj};
      bv        = tv >= {1'b0, qd_src.maj};
      qd_nxt    = qd_src;
      qd_nxt.ru = bu ? 32'(tu - {1'b0, qd_src.maj}) : tu;
      qd_nxt.rv = bv ? 32'(tv - {1'b0, qd_src.maj}) : tv;
      qd_nxt.qu = {qd_src.qu[14:0], bu};
      qd_nxt.qv = {qd_src.qv[14:0], bv};
    end

    always_ff @(posedge clk) begin
      qd_r[j] <= qd_nxt;
    end
  end

  // signed quotient, saturated, plus 32768
  function automatic logic [15:0] q_offset(input logic [15:0] qm, input logic neg,
                                           input logic zmaj);
    logic [15:0] o;
    if (zmaj) begin
      o = 16'd32768;
    end else if (neg) begin
      o = 16'(17'd32768 - {1'b0, qm});
    end else if (qm[15]) begin
      o = 16'd65535;
    end else begin
      o = {1'b1, qm[14:0]};
    end
    return o;
  endfunction

  function automatic logic [11:0] coord(input logic [28:0] p);
    logic [28:0] n;
    n = 29'(p - 29'd32768);
    return (p <= 29'd32768) ? 12'd0 : n[27:16];
  endfunction

  logic [15:0] ou_r;
  logic [15:0] ov_r;
  face_t       face_f_r;
  logic [28:0] pu_r;
  logic [28:0] pv_r;
  face_t       face_g_r;

  always_ff @(posedge clk) begin
    ou_r     <= q_offset(qd_r[QDIV_STEPS-1].qu, qd_r[QDIV_STEPS-1].nu,
                         qd_r[QDIV_STEPS-1].zmaj);
    ov_r     <= q_offset(qd_r[QDIV_STEPS-1].qv, qd_r[QDIV_STEPS-1].nv,
                         qd_r[QDIV_STEPS-1].zmaj);
    face_f_r <= qd_r[QDIV_STEPS-1].face;
    pu_r     <= 29'(ou_r) * 29'(fsize);
    pv_r     <= 29'(ov_r) * 29'(fsize);
    face_g_r <= face_f_r;
  end

  logic [NUM_CH-1:0][31:0] ch_out;
  meta_t                   meta_g;
  out_res_t                out_nxt;
  out_res_t                out_res_r;
  logic                    out_strobe_r;

  assign meta_g = meta_r[META_LAT-1];

  for (genvar c = 0; c < NUM_CH; c++) begin : g_cout
    if (c < CHANNELS) begin : g_used
      assign ch_out[c] = meta_g.size_ok ? meta_g.ch[c] : 32'd0;
    end else begin : g_unused
      assign ch_out[c] = 32'd0;
    end
  end

  always_comb begin
    out_nxt            = '0;
    out_nxt.size_ok    = meta_g.size_ok;
    if (meta_g.size_ok) begin
      out_nxt.face     = face_g_r;
      out_nxt.face_col = coord(pu_r);
      out_nxt.face_row = coord(pv_r);
    end
    out_nxt.chan_out_0 = ch_out[0];
    out_nxt.chan_out_1 = ch_out[1];
    out_nxt.chan_out_2 = ch_out[2];
    out_nxt.chan_out_3 = ch_out[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[META_LAT-1];
    end
    out_res_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(vld_r[0], META_LAT))
    else $error("result strobe without matching request");

  a_bad_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.size_ok |->
      out_res.face == 3'd0 && out_res.face_col == 12'd0 && out_res.face_row == 12'd0)
    else $error("size mismatch result not cleared");

  a_quot: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ANG_STEPS+4+QDIV_STEPS-1] |->
      qd_r[QDIV_STEPS-1].qu <= 16'd32768 && qd_r[QDIV_STEPS-1].qv <= 16'd32768)
    else $error("minor/major quotient out of range");

endmodule

### sv/e2c_sin_rom.sv
// Quarter-wave sine ROM, DEPTH+1 entries, Q0.15 magnitude, registered read.
// Depends on e2c_pkg (quarter_entry).
module e2c_sin_rom #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk,
  input  logic [$clog2(DEPTH+1)-1:0]   addr,
  output logic [14:0]                  data_r
);
  import e2c_pkg::*;

  logic [14:0] tbl [DEPTH+1];

  for (genvar i = 0; i <= DEPTH; i++) begin : g_ent
    localparam logic [63:0] TPOS = (64'(i) << 30) / DEPTH;
    assign tbl[i] = quarter_entry(TPOS);
  end

  always_ff @(posedge clk) begin
    data_r <= tbl[addr];
  end

endmodule

### tb/e2c_checker.sv
`timescale 1ns / 1ps
// Predicts the cube-face mapping of each accepted pixel request and compares it with results.
// Depends on e2c_pkg; watches the request, result and config ports of the mapper.
module e2c_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  e2c_pkg::in_req_t               in_req,
  input  logic                           out_strobe,
  input  e2c_pkg::out_res_t              out_res,
  input  logic                           cfg_we,
  input  logic [e2c_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [e2c_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             pending,
  output int                             results_seen
);
  import e2c_pkg::*;

  localparam int DEPTH = 1024;
  localparam int MAXH  = 8192;

  logic [14:0] img_w;
  logic [13:0] img_h;
  out_res_t    expected_q[$];

  function automatic int sine_entry(int idx);
    logic [63:0] t, t2, acc, r;
    if (idx > DEPTH) idx = DEPTH;
    t   = (64'(idx) << 30) / DEPTH;
    t2  = (t * t) >> 30;
    acc = 64'd172272;
    acc = 64'd5026995 - ((t2 * acc) >> 30);
    acc = 64'd85569306 - ((t2 * acc) >> 30);
    acc = 64'd693598668 - ((t2 * acc) >> 30);
    acc = 64'd1686629713 - ((t2 * acc) >> 30);
    r   = (t * acc) >> 30;
    r   = (r + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return int'(r);
  endfunction

  function automatic int turn_sine(logic [15:0] a);
    logic [1:0] quad;
    int         f, v;
    quad = a[15:14];
    f    = a[13:0];
    if (quad[0]) f = 16384 - f;
    v = sine_entry((f * DEPTH) >> 14);
    return quad[1] ? -v : v;
  endfunction

  function automatic logic [11:0] face_pos(int minor, int major, int fsize);
    longint q, n;
    q = 0;
    if (major != 0) q = (longint'(minor) * 32768) / longint'(major);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    n = (q + 32768) * fsize - 32768;
    if (n <= 0) return '0;
    return n[27:16];
  endfunction

  function automatic out_res_t map_pixel(in_req_t rq);
    out_res_t    res;
    logic [15:0] lon, lat;
    int          cp, sp, ct, st, vx, vy, vz, ax, ay, az, u, v, major;
    face_t       fc;
    res = '0;
    if (img_h == 0 || img_h > MAXH || img_w != 2 * img_h) return res;
    lon = 16'((longint'(rq.src_col) << 16) / img_w);
    lat = 16'((longint'(rq.src_row) << 15) / img_h - 16384);
    cp  = turn_sine(lat + 16'd16384);
    sp  = turn_sine(lat);
    ct  = turn_sine(lon + 16'd16384);
    st  = turn_sine(lon);
    vx  = cp * ct;
    vy  = cp * st;
    vz  = sp * 32768;
    ax  = vx < 0 ? -vx : vx;
    ay  = vy < 0 ? -vy : vy;
    az  = vz < 0 ? -vz : vz;
    if (ax >= ay && ax >= az) begin
      major = ax; u = -vy; v = vz; fc = vx > 0 ? FACE_POS_X : FACE_NEG_X;
    end else if (ay >= az) begin
      major = ay; u = vx; v = vz; fc = vy > 0 ? FACE_POS_Y : FACE_NEG_Y;
    end else begin
      major = az; u = vx; v = -vy; fc = vz > 0 ? FACE_POS_Z : FACE_NEG_Z;
    end
    res.size_ok    = 1'b1;
    res.face       = fc;
    res.face_col   = face_pos(u, major, img_h / 2);
    res.face_row   = face_pos(v, major, img_h / 2);
    res.chan_out_0 = rq.chan_in_0;
    res.chan_out_1 = rq.chan_in_1;
    res.chan_out_2 = rq.chan_in_2;
    res.chan_out_3 = rq.chan_in_3;
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_res_t exp_r;
    if (!rst_n) begin
      img_w        <= 15'd2048;
      img_h        <= 14'd1024;
      mismatches   <= 0;
      results_seen <= 0;
      expected_q.delete();
    end else begin
      if (out_strobe) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h", out_res);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_res !== exp_r) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: ok %b/%b face %0d/%0d col %0d/%0d row %0d/%0d ch %h/%h",
                       exp_r.size_ok, out_res.size_ok, exp_r.face, out_res.face,
                       exp_r.face_col, out_res.face_col, exp_r.face_row, out_res.face_row,
                       {exp_r.chan_out_0, exp_r.chan_out_1, exp_r.chan_out_2,
                        exp_r.chan_out_3},
                       {out_res.chan_out_0, out_res.chan_out_1, out_res.chan_out_2,
                        out_res.chan_out_3});
          end
        end
      end
      if (start && !busy) expected_q.push_back(map_pixel(in_req));
      if (cfg_we) begin
        if (cfg_idx == REG_SOURCE_WIDTH) img_w <= cfg_wdata;
        else if (cfg_idx == REG_SOURCE_HEIGHT) img_h <= cfg_wdata[13:0];
      end
    end
  end
endmodule

### tb/tb_equirect_to_cubemap_mapper_unit.sv
`timescale 1ns / 1ps
// Top of the mapper testbench: clock, reset, config phases and pixel request stimulus.
// Depends on e2c_pkg, equirect_to_cubemap_mapper_unit and e2c_checker.
module tb_equirect_to_cubemap_mapper_unit;
  import e2c_pkg::*;

  localparam int LATENCY = 52;
  localparam int WATCHDOG = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_req_t               in_req = '0;
  logic                  out_strobe;
  out_res_t              out_res;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_SOURCE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    mismatches, pending, results_seen;
  int                    stall_cycles = 0;
  int                    sent = 0;
  int                    cur_w = 2048, cur_h = 1024;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  equirect_to_cubemap_mapper_unit i_dut (.*);

  e2c_checker i_checker (.*);

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG) begin
      $display("watchdog expired");
      $display("[equirect_to_cubemap_mapper_unit] ERROR");
      $finish;
    end
  end

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_SOURCE_WIDTH) cur_w = val;
    else cur_h = val;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_pixel(int col, int row, logic [127:0] ch);
    in_req_t rq;
    rq.src_col = 14'(col);
    rq.src_row = 13'(row);
    {rq.chan_in_0, rq.chan_in_1, rq.chan_in_2, rq.chan_in_3} = ch;
    start  <= 1'b1;
    in_req <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  function automatic logic [127:0] rand_ch();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic random_burst(int n, bit with_gaps, bit in_image);
    int col, row;
    repeat (n) begin
      if (with_gaps && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      if (in_image && $urandom_range(0, 9) != 0) begin
        col = $urandom_range(0, cur_w > 0 ? cur_w - 1 : 0);
        row = $urandom_range(0, cur_h > 0 ? cur_h - 1 : 0);
      end else begin
        col = $urandom_range(0, 16383);
        row = $urandom_range(0, 8191);
      end
      send_pixel(col, row, rand_ch());
    end
    start <= 1'b0;
  endtask

  task automatic set_size(int w, int h);
    set_reg(REG_SOURCE_WIDTH, w);
    set_reg(REG_SOURCE_HEIGHT, h);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset sizes, corners, poles, seams, channel extremes
    send_pixel(0, 0, '0);
    send_pixel(2047, 1023, '1);
    send_pixel(1024, 512, {4{32'h5555_aaaa}});
    send_pixel(512, 512, {4{32'haaaa_5555}});
    send_pixel(1536, 512, rand_ch());
    send_pixel(256, 512, rand_ch());
    send_pixel(0, 256, rand_ch());
    send_pixel(0, 768, rand_ch());
    send_pixel(16383, 8191, '1);
    send_pixel(4096, 2048, rand_ch());
    send_pixel(11111, 5555, rand_ch());
    start <= 1'b0;
    drain();
    // size cases: a mismatch, zero and oversized height, the largest and smallest valid sizes
    set_size(100, 49);
    send_pixel(5, 5, '1);
    start <= 1'b0;
    drain();
    set_size(0, 0);
    send_pixel(0, 0, '1);
    start <= 1'b0;
    drain();
    set_size(16384, 8192);
    send_pixel(16383, 8191, '1);
    send_pixel(8192, 4096, rand_ch());
    send_pixel(0, 0, rand_ch());
    start <= 1'b0;
    drain();
    set_size(32766, 16383);
    send_pixel(3, 3, rand_ch());
    start <= 1'b0;
    drain();
    set_size(2, 1);
    send_pixel(0, 0, rand_ch());
    send_pixel(1, 0, rand_ch());
    start <= 1'b0;
    drain();

    random_burst(200, 1'b1, 1'b1);
    drain();
    set_size(4, 2);
    random_burst(150, 1'b1, 1'b1);
    drain();
    set_size(16384, 8192);
    random_burst(200, 1'b1, 1'b1);
    drain();
    set_size(638, 319);
    random_burst(150, 1'b1, 1'b1);
    drain();
    set_size(1000, 400);
    random_burst(60, 1'b1, 1'b0);
    drain();
    set_size($urandom_range(1, 16383), 0);
    set_reg(REG_SOURCE_HEIGHT, cur_w / 2 > 0 ? cur_w / 2 : 1);
    set_reg(REG_SOURCE_WIDTH, 2 * cur_h);
    random_burst(250, 1'b1, 1'b1);
    drain();
    set_size(2048, 1024);
    random_burst(320, 1'b0, 1'b1);
    drain();

    $display("sent %0d pixel requests, checked %0d results across 10 size settings",
             sent, results_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("[equirect_to_cubemap_mapper_unit] OK");
    end else begin
      $display("[equirect_to_cubemap_mapper_unit] ERROR");
    end
    $finish;
  end
endmodule

### equirect_to_cubemap_mapper_unit.f
sv/e2c_pkg.sv
sv/e2c_sin_rom.sv
sv/equirect_to_cubemap_mapper_unit.sv
tb/e2c_checker.sv
tb/tb_equirect_to_cubemap_mapper_unit.sv
